// File: rtl/brplm_pkg.sv
// Package for the block RMS and peak level meter.
// Holds field widths, fixed constants and the sequencer state type.
// No dependencies.
package brplm_pkg;

  // Field widths
  localparam int unsigned SampleW   = 16;
  localparam int unsigned LevelW    = 16;
  localparam int unsigned AlphaW    = 16;
  localparam int unsigned TotalW    = 32;
  localparam int unsigned BlockLenW = 13;

  // Running average is Q1.15 with 16 more fraction bits
  localparam int unsigned AvgW = 32;

  // Shared multiplier: 17-bit weight by 32-bit operand
  localparam int unsigned MulAW = 17;
  localparam int unsigned MulBW = 32;
  localparam int unsigned ProdW = MulAW + MulBW;

  // Average accumulator holds the sum of both weighted products
  localparam int unsigned AccW = ProdW + 1;

  // Shared compare/subtract unit width
  localparam int unsigned SubW = 32;

  // Square root: mean square is at most 2^30, so 16 digit steps
  localparam int unsigned SqrtSteps = 16;
  localparam logic [SubW-1:0] SqrtFirstBit = SubW'(1) << 30;

  // Register reset value of the average weight
  localparam logic [AlphaW-1:0] AlphaReset = 16'd6554;

  // Weight 1.0 in unsigned 0.16, one bit wider than alpha
  localparam logic [MulAW-1:0] AlphaOne = 17'h10000;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ACC  = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_SQRT = 7'b0001000,
    ST_MUL1 = 7'b0010000,
    ST_MUL2 = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

endpackage

// File: rtl/block_rms_peak_level_meter_core.sv
// Top level of the block RMS and peak level meter.
// Sequencer with one shared multiplier and one shared subtractor.
// Depends on brplm_pkg.

// A sample word is accepted in ST_IDLE, then squared on the shared multiplier
// and added to the block sums in ST_ACC. After the word marked last, the next
// word is accepted only once the block is closed: the mean square is found by
// restoring division, one quotient bit a cycle over the SumW = 30 +
// clog2(MAX_BLOCK + 1) bits of the sum, then the square root takes 16 digit
// steps, both on one shared subtractor; the running average is formed on the
// shared multiplier in ST_MUL1 and ST_MUL2, and ST_DONE loads the result
// register. The result register frees the sequencer while a result waits; a
// next last word waits only if the previous result is still not taken. Levels
// are Q1.15; a peak of -32768 reads as 32768.
// average_alpha may be written at any time the meter is idle.
module block_rms_peak_level_meter_core import brplm_pkg::*; #(
  parameter int unsigned MAX_BLOCK = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [AlphaW-1:0]    cfg_average_alpha_i,
  // sample input
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                 last_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LevelW-1:0]    rms_level_o,
  output logic [LevelW-1:0]    peak_level_o,
  output logic [LevelW-1:0]    average_level_o,
  output logic [TotalW-1:0]    total_samples_o,
  output logic [BlockLenW-1:0] block_length_o,
  output logic                 block_overflow_o
);

  localparam int unsigned CountW  = $clog2(MAX_BLOCK + 1);
  localparam int unsigned SumW    = 30 + CountW;
  localparam int unsigned StepW   = $clog2(SumW);
  localparam int unsigned LenExtW = CountW + BlockLenW;

  localparam logic [CountW-1:0] CountMax = CountW'(MAX_BLOCK);
  localparam logic [StepW-1:0]  DivLast  = StepW'(SumW - 1);
  localparam logic [StepW-1:0]  SqrtLast = StepW'(SqrtSteps - 1);

  // Sequencer and block state
  state_e state_q, state_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [LevelW-1:0]  peak_q, peak_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [TotalW-1:0]  total_q, total_d;
  logic [AvgW-1:0]    avg_q, avg_d;
  logic               ovf_q, ovf_d;
  logic [AlphaW-1:0]  alpha_q;

  // Working registers
  logic [LevelW-1:0]  mag_q, mag_d;
  logic               last_q, last_d;
  logic [CountW-1:0]  rem_q, rem_d;
  logic [SubW-1:0]    val_q, val_d;
  logic [SubW-1:0]    root_q, root_d;
  logic [SubW-1:0]    bit_q, bit_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [AccW-1:0]    acc_q, acc_d;

  // Result register
  logic               out_valid_q, out_valid_d;
  logic               res_load;
  logic [LevelW-1:0]  rms_q, peak_out_q, avg_out_q;
  logic [TotalW-1:0]  total_out_q;
  logic [BlockLenW-1:0] len_out_q;
  logic               ovf_out_q;

  // Shared units
  logic [MulAW-1:0]   mul_a;
  logic [MulBW-1:0]   mul_b;
  logic [ProdW-1:0]   prod;
  logic [SubW-1:0]    sub_a, sub_b;
  logic [SubW:0]      diff;
  logic               borrow;

  // Misc combinational values
  logic [LevelW-1:0]  mag_in;
  logic [CountW:0]    rem_shift;
  logic [LevelW:0]    avg_round;
  logic [LenExtW-1:0] len_ext;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Magnitude of the incoming sample; -32768 maps to 32768 in 16 bits
  assign mag_in = sample_i[SampleW-1] ? (LevelW'(0) - LevelW'(sample_i))
                                      : LevelW'(sample_i);

  // Partial remainder with the next dividend bit shifted in
  assign rem_shift = {rem_q, sum_q[SumW-1]};

  // Shared multiplier operand select
  always_comb begin
    unique case (state_q)
      ST_MUL1: begin
        mul_a = AlphaOne - MulAW'(alpha_q);
        mul_b = avg_q;
      end
      ST_MUL2: begin
        mul_a = MulAW'(alpha_q);
        mul_b = MulBW'(root_q[LevelW-1:0]);
      end
      default: begin
        mul_a = MulAW'(mag_q);
        mul_b = MulBW'(mag_q);
      end
    endcase
  end
  assign prod = ProdW'(mul_a) * ProdW'(mul_b);

  // Shared subtractor operand select
  always_comb begin
    unique case (state_q)
      ST_SQRT: begin
        sub_a = val_q;
        sub_b = root_q + bit_q;
      end
      default: begin
        sub_a = SubW'(rem_shift);
        sub_b = SubW'(count_q);
      end
    endcase
  end
  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow = diff[SubW];

  // Round the running average half up to Q1.15
  assign avg_round = (LevelW + 1)'(avg_q[AvgW-1:LevelW]) + (LevelW + 1)'(avg_q[LevelW-1]);
  assign len_ext   = LenExtW'(count_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    peak_d      = peak_q;
    count_d     = count_q;
    total_d     = total_q;
    avg_d       = avg_q;
    ovf_d       = ovf_q;
    mag_d       = mag_q;
    last_d      = last_q;
    rem_d       = rem_q;
    val_d       = val_q;
    root_d      = root_q;
    bit_d       = bit_q;
    step_d      = step_q;
    acc_d       = acc_q;
    res_load    = 1'b0;
    out_valid_d = out_valid_q;

    // drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        // capture the word
        if (in_valid_i) begin
          mag_d   = mag_in;
          last_d  = last_i;
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        // accumulate the square unless the block is full
        if (count_q == CountMax) begin
          ovf_d = 1'b1;
        end else begin
          sum_d   = sum_q + SumW'(prod[2*LevelW-1:0]);
          count_d = count_q + CountW'(1);
        end
        if (mag_q > peak_q) begin
          peak_d = mag_q;
        end
        total_d = total_q + TotalW'(1);
        if (last_q) begin
          rem_d   = '0;
          val_d   = '0;
          step_d  = '0;
          state_d = ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle, quotient shifts into val
        if (borrow) begin
          rem_d = rem_shift[CountW-1:0];
        end else begin
          rem_d = diff[CountW-1:0];
        end
        val_d  = {val_q[SubW-2:0], ~borrow};
        sum_d  = sum_q << 1;
        step_d = step_q + StepW'(1);
        if (step_q == DivLast) begin
          root_d  = '0;
          bit_d   = SqrtFirstBit;
          step_d  = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        // one root digit per cycle
        if (!borrow) begin
          val_d  = diff[SubW-1:0];
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d  = bit_q >> 2;
        step_d = step_q + StepW'(1);
        if (step_q == SqrtLast) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        // old average weighted by one minus alpha
        acc_d   = AccW'(prod);
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        // add new RMS weighted by alpha, keep Q1.31
        acc_d   = acc_q + (AccW'(prod) << LevelW);
        avg_d   = acc_d[AvgW+LevelW-1:LevelW];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register is free, then clear the block
        if (!out_valid_q || out_ready_i) begin
          res_load    = 1'b1;
          out_valid_d = 1'b1;
          sum_d       = '0;
          peak_d      = '0;
          count_d     = '0;
          ovf_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      peak_q      <= '0;
      count_q     <= '0;
      total_q     <= '0;
      avg_q       <= '0;
      ovf_q       <= 1'b0;
      alpha_q     <= AlphaReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      peak_q      <= peak_d;
      count_q     <= count_d;
      total_q     <= total_d;
      avg_q       <= avg_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        alpha_q <= cfg_average_alpha_i;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    last_q <= last_d;
    rem_q  <= rem_d;
    val_q  <= val_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    step_q <= step_d;
    acc_q  <= acc_d;
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      rms_q       <= root_q[LevelW-1:0];
      peak_out_q  <= peak_q;
      avg_out_q   <= avg_round[LevelW-1:0];
      total_out_q <= total_q;
      len_out_q   <= len_ext[BlockLenW-1:0];
      ovf_out_q   <= ovf_q;
    end
  end

  assign rms_level_o      = rms_q;
  assign peak_level_o     = peak_out_q;
  assign average_level_o  = avg_out_q;
  assign total_samples_o  = total_out_q;
  assign block_length_o   = len_out_q;
  assign block_overflow_o = ovf_out_q;

  // Checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountMax)
    else $error("block count beyond maximum");

  a_sqrt_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> $onehot(bit_q))
    else $error("square root digit bit lost");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the final state");

endmodule

// File: test/level_meter_checker.sv
// Checker for the block RMS and peak level meter: watches the config, sample
// and result channels, predicts each level word and compares it field by field.
// Depends on brplm_pkg.
module level_meter_checker import brplm_pkg::*; #(
  parameter int unsigned MAX_BLOCK = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [AlphaW-1:0]         cfg_average_alpha_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      last_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [LevelW-1:0]         rms_level_i,
  input  logic [LevelW-1:0]         peak_level_i,
  input  logic [LevelW-1:0]         average_level_i,
  input  logic [TotalW-1:0]         total_samples_i,
  input  logic [BlockLenW-1:0]      block_length_i,
  input  logic                      block_overflow_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        results_o
);

  typedef struct packed {
    logic [LevelW-1:0]    rms;
    logic [LevelW-1:0]    peak;
    logic [LevelW-1:0]    avg;
    logic [TotalW-1:0]    total;
    logic [BlockLenW-1:0] len;
    logic                 ovf;
  } level_word_t;

  // Predicted meter state
  logic [42:0]          energy_sum;
  logic [LevelW-1:0]    peak_mag;
  logic [BlockLenW-1:0] block_len;
  logic [TotalW-1:0]    seen_total;
  logic [AvgW-1:0]      level_avg;
  logic                 block_ovf;
  logic [AlphaW-1:0]    alpha_reg;

  level_word_t level_q[$];
  int          mismatches;
  int          checked;

  // Largest root whose square does not exceed the mean square
  function automatic logic [LevelW-1:0] floor_sqrt(input logic [63:0] value);
    logic [63:0] root;
    logic [63:0] trial;
    int          b;
    root = '0;
    for (b = LevelW - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= value) root = trial;
    end
    return root[LevelW-1:0];
  endfunction

  // Fold one sample word into the block sums; close the block on last
  task automatic predict_word(input logic signed [SampleW-1:0] value, input logic is_last);
    int          sv;
    int          mag;
    logic [63:0] mean_sq;
    logic [63:0] acc;
    level_word_t w;
    sv  = value;
    mag = (sv < 0) ? -sv : sv;
    if (block_len >= MAX_BLOCK) begin
      block_ovf = 1'b1;
    end else begin
      energy_sum = energy_sum + 43'(mag * mag);
      block_len  = block_len + 1'b1;
    end
    if (mag > peak_mag) peak_mag = LevelW'(mag);
    seen_total = seen_total + 1'b1;
    if (is_last) begin
      mean_sq   = 64'(energy_sum) / 64'(block_len);
      w.rms     = floor_sqrt(mean_sq);
      acc       = (64'd65536 - 64'(alpha_reg)) * 64'(level_avg)
                + 64'(alpha_reg) * (64'(w.rms) << 16);
      level_avg = acc[47:16];
      w.avg     = LevelW'((64'(level_avg) + 64'h8000) >> 16);
      w.peak    = peak_mag;
      w.total   = seen_total;
      w.len     = block_len;
      w.ovf     = block_ovf;
      level_q.push_back(w);
      energy_sum = '0;
      peak_mag   = '0;
      block_len  = '0;
      block_ovf  = 1'b0;
    end
  endtask

  // Compare one accepted level word with the oldest prediction
  task automatic check_level_word();
    level_word_t got;
    level_word_t want;
    got = '{rms: rms_level_i, peak: peak_level_i, avg: average_level_i,
            total: total_samples_i, len: block_length_i, ovf: block_overflow_i};
    checked++;
    if (level_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected level word: rms %0d peak %0d avg %0d total %0d len %0d ovf %0d",
                 got.rms, got.peak, got.avg, got.total, got.len, got.ovf);
    end else begin
      want = level_q.pop_front();
      if (got.rms != want.rms || got.peak != want.peak || got.avg != want.avg ||
          got.total != want.total || got.len != want.len || got.ovf != want.ovf) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("level word %0d mismatch", checked);
          $display("  expected rms %0d peak %0d avg %0d total %0d len %0d ovf %0d",
                   want.rms, want.peak, want.avg, want.total, want.len, want.ovf);
          $display("  actual   rms %0d peak %0d avg %0d total %0d len %0d ovf %0d",
                   got.rms, got.peak, got.avg, got.total, got.len, got.ovf);
        end
      end
    end
  endtask

  // Track every handshake; publish counts with nonblocking updates
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_sum = '0;
      peak_mag   = '0;
      block_len  = '0;
      seen_total = '0;
      level_avg  = '0;
      block_ovf  = 1'b0;
      alpha_reg  = AlphaReset;
      level_q.delete();
      mismatches = 0;
      checked    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) alpha_reg = cfg_average_alpha_i;
      if (in_valid_i && in_ready_i) predict_word(sample_i, last_i);
      if (out_valid_i && out_ready_i) check_level_word();
      fail_count_o <= mismatches;
      pending_o    <= level_q.size();
      results_o    <= checked;
    end
  end

endmodule

// File: test/tb_top.sv
// Top of the level meter regression: clock, reset, sample and config stimulus,
// receiver back-pressure and the verdict.
// Depends on brplm_pkg, block_rms_peak_level_meter_core and level_meter_checker.
module tb_top import brplm_pkg::*;;

  localparam int unsigned MaxBlock     = 4096;
  localparam int          DrainCycles  = 80;
  localparam int          LimitCycles  = 500000;
  localparam int          RandomPhases = 6;
  localparam int          PhaseWords   = 100;

  typedef enum int {RX_ALWAYS = 0, RX_COIN = 1, RX_LONG = 2} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [AlphaW-1:0] cfg_alpha = '0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [SampleW-1:0] sample = '0;
  logic                      last_flag = 1'b0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [LevelW-1:0]    rms_level;
  logic [LevelW-1:0]    peak_level;
  logic [LevelW-1:0]    average_level;
  logic [TotalW-1:0]    total_samples;
  logic [BlockLenW-1:0] block_length;
  logic                 block_overflow;

  int fail_count;
  int pending;
  int results;

  // Sender and receiver pacing
  rx_mode_e rx_mode = RX_ALWAYS;
  int       rx_hold = 0;
  logic     tx_bursty = 1'b0;
  int       burst_left = 0;
  int       words_sent = 0;
  int       alpha_writes = 0;
  int       cycle_count = 0;

  // Directed words as {last, sample}
  logic [SampleW:0] directed_words [22] = '{
    17'h18000, 17'h17FFF, 17'h10000, 17'h0FFFF, 17'h00001, 17'h18001,
    17'h07FFF, 17'h18000, 17'h05555, 17'h0AAAA, 17'h05555, 17'h0AAAA,
    17'h000FF, 17'h0FF00, 17'h00F0F, 17'h1F0F0, 17'h00000, 17'h00000,
    17'h00000, 17'h00000, 17'h00000, 17'h10007
  };

  block_rms_peak_level_meter_core #(
    .MAX_BLOCK(MaxBlock)
  ) i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_average_alpha_i (cfg_alpha),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .sample_i            (sample),
    .last_i              (last_flag),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .rms_level_o         (rms_level),
    .peak_level_o        (peak_level),
    .average_level_o     (average_level),
    .total_samples_o     (total_samples),
    .block_length_o      (block_length),
    .block_overflow_o    (block_overflow)
  );

  level_meter_checker #(
    .MAX_BLOCK(MaxBlock)
  ) i_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_average_alpha_i (cfg_alpha),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .sample_i            (sample),
    .last_i              (last_flag),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .rms_level_i         (rms_level),
    .peak_level_i        (peak_level),
    .average_level_i     (average_level),
    .total_samples_i     (total_samples),
    .block_length_i      (block_length),
    .block_overflow_i    (block_overflow),
    .fail_count_o        (fail_count),
    .pending_o           (pending),
    .results_o           (results)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LimitCycles) begin
      $display("timeout after %0d cycles with %0d level words outstanding",
               cycle_count, pending);
      $display("block_rms_peak_level_meter_core regression: fail");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    case (rx_mode)
      RX_ALWAYS: out_ready = 1'b1;
      RX_COIN:   out_ready = ($urandom_range(0, 2) != 0);
      default: begin
        if (rx_hold == 0) begin
          out_ready = !out_ready;
          rx_hold = out_ready ? $urandom_range(1, 6) : $urandom_range(1, 30);
        end else begin
          rx_hold = rx_hold - 1;
        end
      end
    endcase
  end

  // Skew toward full scale, zero and sign boundaries
  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'($urandom_range(0, 31));
      default: return 16'($urandom());
    endcase
  endfunction

  // Present one sample word and hold it until taken
  task automatic put_word(input logic [SampleW-1:0] value, input logic is_last);
    int gap;
    if (tx_bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        repeat (gap) begin
          @(negedge clk);
          in_valid = 1'b0;
        end
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left = burst_left - 1;
      end
    end
    @(negedge clk);
    in_valid  = 1'b1;
    sample    = value;
    last_flag = is_last;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_block(input int len);
    int i;
    for (i = 1; i <= len; i++) put_word(pick_sample(), i == len);
  endtask

  // Drop valid and wait until every level word is out and the core is quiet
  task automatic wait_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_alpha(input logic [AlphaW-1:0] value);
    wait_quiet();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_alpha = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    alpha_writes++;
  endtask

  // Main sequence
  initial begin
    int i;
    int phase;
    int phase_words;
    int len;
    int pick;
    logic [AlphaW-1:0] alpha;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Extremes and bit patterns at the reset weight
    rx_mode = RX_COIN;
    for (i = 0; i < 22; i++) put_word(directed_words[i][SampleW-1:0], directed_words[i][SampleW]);

    // Random blocks across weight settings and pacing patterns
    for (phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0:       alpha = 16'h0000;
        1:       alpha = 16'hFFFF;
        2:       alpha = 16'h0001;
        3:       alpha = 16'h8000;
        default: alpha = 16'($urandom_range(0, 65535));
      endcase
      write_alpha(alpha);
      tx_bursty = (phase != 0);
      rx_mode   = rx_mode_e'(phase % 3);
      phase_words = 0;
      while (phase_words < PhaseWords) begin
        pick = $urandom_range(0, 99);
        if (pick < 75)      len = $urandom_range(1, 8);
        else if (pick < 95) len = $urandom_range(9, 40);
        else                len = $urandom_range(41, 200);
        send_block(len);
        phase_words += len;
      end
    end

    wait_quiet();
    $display("sent %0d sample words: directed extremes, then random blocks of 1 to 200",
             words_sent);
    $display("checked %0d level words over %0d weight writes", results, alpha_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("block_rms_peak_level_meter_core regression: pass");
    end else begin
      $display("mismatches %0d, level words never seen %0d", fail_count, pending);
      $display("block_rms_peak_level_meter_core regression: fail");
    end
    $finish;
  end

endmodule
